// ===== sv/ewt_pkg.sv =====
`timescale 1ns / 1ps

package ewt_pkg;

  // Table geometry
  localparam int unsigned EVENT_SLOTS    = 64;
  localparam int unsigned SLOT_BITS      = $clog2(EVENT_SLOTS);
  localparam int unsigned STREAM_ID_BITS = 16;
  localparam int unsigned COUNT_BITS     = 7;

  // APB register map
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam logic [0:0]  REG_ACTIVE_IDS = 1'b0;
  localparam logic [COUNT_BITS-1:0] ACTIVE_IDS_RST = COUNT_BITS'(EVENT_SLOTS);

  // Request opcodes
  typedef enum logic [2:0] {
    ACT_SIGNAL = 3'd0,
    ACT_WAIT   = 3'd1,
    ACT_RESET  = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_LIST   = 3'd4
  } action_e;

endpackage

// ===== sv/event_wait_table.sv =====
`timescale 1ns / 1ps

// Event wait table: per-slot arrived flag plus an optional waiting stream.
// Request channel (in_valid_i / in_stall_o) carries action_i, event_id_i and
// stream_id_i; a request is taken on a clock edge with valid high and stall low.
// Result channel (out_valid_o / out_stall_i) returns one result per request,
// or for the list action one per waiting slot or one empty, last_o on the final.
// Signal, wait, reset, clear: the stream memory is read as the request is
// taken; in ST_EXEC the flags update, a wait writes its stream back and the
// result is loaded into the output register. A new request is taken only in
// ST_IDLE. List: one slot below the active count (saturated at 64) is scanned
// per cycle while no hit waits on a stalled result side. The result sits in
// an output register and holds while the receiver stalls, when an idle table
// still takes a new request; the sender is stalled whenever a request is in
// flight. Reset clears all arrived flags and waiters at once (no clearing
// pass) and sets active_ids to 64. Configuration is written over APB,
// register 0 at byte address 0; the user must write it only while no request
// is in flight, which the block itself does not enforce.
module event_wait_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ewt_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [ewt_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [ewt_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          action_i,
  input  logic [ewt_pkg::SLOT_BITS-1:0]       event_id_i,
  input  logic [ewt_pkg::STREAM_ID_BITS-1:0]  stream_id_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                status_o,
  output logic                                released_o,
  output logic [ewt_pkg::STREAM_ID_BITS-1:0]  released_stream_o,
  output logic                                must_wait_o,
  output logic                                waiting_found_o,
  output logic [ewt_pkg::SLOT_BITS-1:0]       waiting_id_o,
  output logic                                last_o
);

  import ewt_pkg::*;

  logic [COUNT_BITS-1:0]     active_ids;
  logic                      mem_re, mem_we;
  logic [SLOT_BITS-1:0]      mem_raddr, mem_waddr;
  logic [STREAM_ID_BITS-1:0] mem_rdata, mem_wdata;

  ewt_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_o     (prdata),
    .pready_o     (pready),
    .active_ids_o (active_ids)
  );

  // Waiting stream per slot
  ewt_ram #(
    .DEPTH (EVENT_SLOTS),
    .WIDTH (STREAM_ID_BITS)
  ) u_stream_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ewt_core u_core (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .active_ids_i          (active_ids),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_action_i           (action_i),
    .in_event_id_i         (event_id_i),
    .in_stream_id_i        (stream_id_i),
    .mem_re_o              (mem_re),
    .mem_raddr_o           (mem_raddr),
    .mem_rdata_i           (mem_rdata),
    .mem_we_o              (mem_we),
    .mem_waddr_o           (mem_waddr),
    .mem_wdata_o           (mem_wdata),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_status_o          (status_o),
    .out_released_o        (released_o),
    .out_released_stream_o (released_stream_o),
    .out_must_wait_o       (must_wait_o),
    .out_waiting_found_o   (waiting_found_o),
    .out_waiting_id_o      (waiting_id_o),
    .out_last_o            (last_o)
  );

endmodule

// ===== sv/ewt_ram.sv =====
`timescale 1ns / 1ps

module ewt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ewt_cfg.sv =====
`timescale 1ns / 1ps

module ewt_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [ewt_pkg::APB_ADDR_BITS-1:0]  paddr_i,
  input  logic [ewt_pkg::APB_DATA_BITS-1:0]  pwdata_i,
  output logic [ewt_pkg::APB_DATA_BITS-1:0]  prdata_o,
  output logic                               pready_o,
  output logic [ewt_pkg::COUNT_BITS-1:0]     active_ids_o
);

  import ewt_pkg::*;

  logic [COUNT_BITS-1:0] active_ids_q;
  logic                  wr_en;
  logic                  sel_active;

  assign pready_o   = 1'b1;
  assign sel_active = (paddr_i[APB_ADDR_BITS-1] == REG_ACTIVE_IDS);
  assign wr_en      = psel_i & penable_i & pwrite_i & pready_o;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_ids_q <= ACTIVE_IDS_RST;
    end else if (wr_en && sel_active) begin
      active_ids_q <= pwdata_i[COUNT_BITS-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata_o = '0;
    if (sel_active) begin
      prdata_o = {{(APB_DATA_BITS-COUNT_BITS){1'b0}}, active_ids_q};
    end
  end

  assign active_ids_o = active_ids_q;

endmodule

// ===== sv/ewt_core.sv =====
`timescale 1ns / 1ps

module ewt_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ewt_pkg::COUNT_BITS-1:0]      active_ids_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          in_action_i,
  input  logic [ewt_pkg::SLOT_BITS-1:0]       in_event_id_i,
  input  logic [ewt_pkg::STREAM_ID_BITS-1:0]  in_stream_id_i,
  // waiter stream memory
  output logic                                mem_re_o,
  output logic [ewt_pkg::SLOT_BITS-1:0]       mem_raddr_o,
  input  logic [ewt_pkg::STREAM_ID_BITS-1:0]  mem_rdata_i,
  output logic                                mem_we_o,
  output logic [ewt_pkg::SLOT_BITS-1:0]       mem_waddr_o,
  output logic [ewt_pkg::STREAM_ID_BITS-1:0]  mem_wdata_o,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_status_o,
  output logic                                out_released_o,
  output logic [ewt_pkg::STREAM_ID_BITS-1:0]  out_released_stream_o,
  output logic                                out_must_wait_o,
  output logic                                out_waiting_found_o,
  output logic [ewt_pkg::SLOT_BITS-1:0]       out_waiting_id_o,
  output logic                                out_last_o
);

  import ewt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_e;

  state_e                    state_q, state_d;
  logic [2:0]                act_q;
  logic [SLOT_BITS-1:0]      id_q;
  logic [STREAM_ID_BITS-1:0] stream_q;
  logic [SLOT_BITS-1:0]      cnt_q, cnt_d;
  logic [EVENT_SLOTS-1:0]    arrived_q, arrived_d;
  logic [EVENT_SLOTS-1:0]    wvalid_q, wvalid_d;

  logic                      out_valid_q;
  logic                      out_status_q, out_released_q, out_must_wait_q;
  logic                      out_found_q, out_last_q;
  logic [STREAM_ID_BITS-1:0] out_rstream_q;
  logic [SLOT_BITS-1:0]      out_wid_q;

  logic                      ld;
  logic                      res_status, res_released, res_must_wait, res_found, res_last;
  logic [STREAM_ID_BITS-1:0] res_rstream;
  logic [SLOT_BITS-1:0]      res_wid;

  logic                      accept;
  logic                      out_busy;
  logic [COUNT_BITS-1:0]     limit;
  logic [EVENT_SLOTS-1:0]    lim_mask;
  logic [EVENT_SLOTS-1:0]    above_mask;
  logic                      id_err;
  logic                      more;
  logic                      any_wait;
  logic                      hit;

  assign accept     = in_valid_i & (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_busy   = out_valid_q & out_stall_i;

  // Active count, saturated to the table size
  assign limit      = (active_ids_i > COUNT_BITS'(EVENT_SLOTS)) ?
                      COUNT_BITS'(EVENT_SLOTS) : active_ids_i;
  assign lim_mask   = ~({EVENT_SLOTS{1'b1}} << limit);
  assign id_err     = ({1'b0, id_q} >= limit);
  assign above_mask = {EVENT_SLOTS{1'b1}} << ({1'b0, cnt_q} + COUNT_BITS'(1));
  assign more       = |(wvalid_q & lim_mask & above_mask);
  assign any_wait   = |(wvalid_q & lim_mask);
  assign hit        = wvalid_q[cnt_q] & lim_mask[cnt_q];

  // Stream read is issued with the request; data is ready in ST_EXEC
  assign mem_re_o    = accept;
  assign mem_raddr_o = in_event_id_i;
  assign mem_waddr_o = id_q;
  assign mem_wdata_o = stream_q;

  // Next-state and result logic
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    arrived_d     = arrived_q;
    wvalid_d      = wvalid_q;
    ld            = 1'b0;
    mem_we_o      = 1'b0;
    res_status    = 1'b0;
    res_released  = 1'b0;
    res_rstream   = '0;
    res_must_wait = 1'b0;
    res_found     = 1'b0;
    res_wid       = '0;
    res_last      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (!out_busy) begin
          ld      = 1'b1;
          state_d = ST_IDLE;
          if (act_q == ACT_LIST) begin
            // walk only when some slot waits; otherwise a single empty result
            if (any_wait) begin
              ld      = 1'b0;
              state_d = ST_LIST;
              cnt_d   = '0;
            end
          end else if (act_q > ACT_LIST) begin
            // unknown opcode: empty result
          end else if (id_err) begin
            res_status = 1'b1;
          end else begin
            case (act_q)
              ACT_SIGNAL: begin
                arrived_d[id_q] = 1'b1;
                if (wvalid_q[id_q]) begin
                  res_released   = 1'b1;
                  res_rstream    = mem_rdata_i;
                  wvalid_d[id_q] = 1'b0;
                end
              end
              ACT_WAIT: begin
                if (!arrived_q[id_q]) begin
                  mem_we_o       = 1'b1;
                  wvalid_d[id_q] = 1'b1;
                  res_must_wait  = 1'b1;
                end else begin
                  arrived_d[id_q] = 1'b0;
                end
              end
              ACT_RESET: begin
                arrived_d[id_q] = 1'b0;
              end
              default: begin
                arrived_d[id_q] = 1'b0;
                wvalid_d[id_q]  = 1'b0;
              end
            endcase
          end
        end
      end

      ST_LIST: begin
        if (hit) begin
          if (!out_busy) begin
            ld        = 1'b1;
            res_found = 1'b1;
            res_wid   = cnt_q;
            res_last  = ~more;
            if (more) begin
              cnt_d = cnt_q + SLOT_BITS'(1);
            end else begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          cnt_d = cnt_q + SLOT_BITS'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, table flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      act_q           <= '0;
      id_q            <= '0;
      stream_q        <= '0;
      cnt_q           <= '0;
      arrived_q       <= '0;
      wvalid_q        <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= 1'b0;
      out_released_q  <= 1'b0;
      out_rstream_q   <= '0;
      out_must_wait_q <= 1'b0;
      out_found_q     <= 1'b0;
      out_wid_q       <= '0;
      out_last_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      arrived_q <= arrived_d;
      wvalid_q  <= wvalid_d;
      if (accept) begin
        act_q    <= in_action_i;
        id_q     <= in_event_id_i;
        stream_q <= in_stream_id_i;
      end
      out_valid_q <= ld | out_busy;
      if (ld) begin
        out_status_q    <= res_status;
        out_released_q  <= res_released;
        out_rstream_q   <= res_rstream;
        out_must_wait_q <= res_must_wait;
        out_found_q     <= res_found;
        out_wid_q       <= res_wid;
        out_last_q      <= res_last;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_status_q;
  assign out_released_o        = out_released_q;
  assign out_released_stream_o = out_rstream_q;
  assign out_must_wait_o       = out_must_wait_q;
  assign out_waiting_found_o   = out_found_q;
  assign out_waiting_id_o      = out_wid_q;
  assign out_last_o            = out_last_q;

`ifndef SYNTHESIS
  // The walk always has an in-range waiter at or after the cursor
  a_list_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |->
      |(wvalid_q & lim_mask & ({EVENT_SLOTS{1'b1}} << {1'b0, cnt_q})))
    else $error("list walk without a pending waiter");

  // Waiter bits do not move while a list walk is running
  a_list_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |=> $stable(wvalid_q))
    else $error("waiter bits changed during list walk");

  // A released waiter frees its slot
  a_release_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && res_released) |=> !wvalid_q[$past(id_q)])
    else $error("released slot still holds a waiter");

  // List results never carry single-slot fields
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |->
      (!out_status_q && !out_released_q && !out_must_wait_q))
    else $error("list result mixed with slot result");
`endif

endmodule
